FILE: rtl/core/bsl_pkg.sv
// shared types, constants and helpers for the byte stream lexer
`default_nettype none
package bsl_pkg;

   localparam int OFFSET_BITS   = 32;
   localparam int LENGTH_BITS   = 16;
   localparam int POSITION_BITS = 24;
   localparam int KIND_BITS     = 3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   localparam logic [KIND_BITS-1:0] KIND_IDENT  = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_NUMBER = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_OPEN   = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_CLOSE  = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_COMMA  = 3'd4;
   localparam logic [KIND_BITS-1:0] KIND_END    = 3'd5;
   localparam logic [KIND_BITS-1:0] KIND_UNREC  = 3'd6;

   localparam logic [LENGTH_BITS-1:0]   LENGTH_MAX   = '1;
   localparam logic [POSITION_BITS-1:0] POSITION_MAX = '1;
   localparam logic [POSITION_BITS-1:0] POSITION_ONE = POSITION_BITS'(1);

   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_LE    = 8'h65;
   localparam logic [7:0] CH_UE    = 8'h45;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_OPEN  = 8'h28;
   localparam logic [7:0] CH_CLOSE = 8'h29;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_SPACE = 8'h20;

   typedef enum logic [3:0] {
      MODE_IDLE,
      MODE_COMMENT,
      MODE_MINUS,
      MODE_IDENT,
      MODE_INT,
      MODE_FRAC,
      MODE_EXPMARK,
      MODE_EXPSIGN,
      MODE_EXPDIG
   } mode_type;

   typedef struct packed {
      logic [OFFSET_BITS-1:0]   off;
      logic [POSITION_BITS-1:0] line;
      logic [POSITION_BITS-1:0] col;
   } pos_type;

   typedef struct packed {
      logic [7:0] b;
      pos_type    p;
   } rp_type;

   typedef struct packed {
      logic [KIND_BITS-1:0]     kind;
      logic [OFFSET_BITS-1:0]   offset;
      logic [LENGTH_BITS-1:0]   length;
      logic [POSITION_BITS-1:0] line;
      logic [POSITION_BITS-1:0] column;
      logic                     last;
   } token_type;

   typedef struct packed {
      logic      v;
      token_type t;
   } emit_type;

   typedef struct packed {
      token_type [2:0] tok;
      logic [1:0]      count;
   } bundle_type;

   typedef struct packed {
      mode_type                 mode;
      logic [7:0]               held0;
      logic [7:0]               held1;
      logic [1:0]               held_count;
      logic                     digit_seen;
      logic [OFFSET_BITS-1:0]   open_start;
      logic [LENGTH_BITS-1:0]   open_length;
      logic [POSITION_BITS-1:0] open_line;
      logic [POSITION_BITS-1:0] open_col;
   } scan_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_head(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) || (c == CH_UNDER);
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) || (c == CH_CR) ||
             (c == CH_VT) || (c == CH_FF);
   endfunction

   function automatic logic [LENGTH_BITS-1:0] len_add(input logic [LENGTH_BITS-1:0] x,
                                                      input logic [1:0] k);
      logic [LENGTH_BITS:0] s;
      s = {1'b0, x} + {{(LENGTH_BITS-1){1'b0}}, k};
      return (s > {1'b0, LENGTH_MAX}) ? LENGTH_MAX : s[LENGTH_BITS-1:0];
   endfunction

   function automatic logic [POSITION_BITS-1:0] pos_inc(input logic [POSITION_BITS-1:0] x);
      return (x == POSITION_MAX) ? x : x + POSITION_ONE;
   endfunction

   function automatic logic [POSITION_BITS-1:0] pos_back(input logic [POSITION_BITS-1:0] x,
                                                         input logic [1:0] k);
      logic [POSITION_BITS-1:0] kk;
      kk = {{(POSITION_BITS-2){1'b0}}, k};
      return (x > kk) ? x - kk : POSITION_ONE;
   endfunction

   function automatic token_type mk_tok(input logic [KIND_BITS-1:0] kind,
                                        input logic [OFFSET_BITS-1:0] off,
                                        input logic [LENGTH_BITS-1:0] len,
                                        input logic [POSITION_BITS-1:0] line,
                                        input logic [POSITION_BITS-1:0] col);
      token_type t;
      t.kind   = kind;
      t.offset = off;
      t.length = len;
      t.line   = line;
      t.column = col;
      t.last   = 1'b0;
      return t;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/bsl_front.sv
// front end: takes bytes, scans one per cycle unless q_full, bundles tokens per word
`default_nettype none
module bsl_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_push,
   output logic                     req_full,
   input  wire logic [7:0]          req_byte_value,
   input  wire logic                req_byte_present,
   input  wire logic                req_source_ends,
   input  wire logic                q_full,
   output logic                     bundle_push,
   output bsl_pkg::bundle_type      bundle
);
   import bsl_pkg::*;

   typedef struct packed {
      scan_type s;
      emit_type e;
   } beg_type;

   scan_type scan_ff, scan_in, sn, scan_rst;
   logic [1:0] rp_n_ff, rp_n_in, w_rp_n, nrp_n;
   rp_type [1:0] rp_ff, rp_in, w_rp, nrp;
   logic c_v_ff, c_v_in, w_c_v;
   rp_type c_ff, c_in, w_c;
   logic e_v_ff, e_v_in, w_e_v;
   pos_type e_ff, e_in, w_e;
   logic carry_v_ff, carry_v_in;
   token_type carry_ff, carry_in;
   logic [OFFSET_BITS-1:0] off_ff, off_in;
   logic [POSITION_BITS-1:0] line_ff, line_in, col_ff, col_in;
   pos_type cnt_now, cnt_after;

   logic busy, accept, h_rp, heof, has_head, step_en, consumed, item_final;
   logic [7:0] hb;
   pos_type hp;
   logic dig, isdot, is_e, sign, minus, body, nl;
   logic fin, bt;
   logic [KIND_BITS-1:0] fin_kind;
   emit_type e0, e1;
   beg_type bg;
   token_type [2:0] tv, lst;
   logic [2:0] vv;
   logic [1:0] n;

   function automatic beg_type beg(input logic [7:0] b, input logic eof, input pos_type p,
                                   input scan_type si);
      beg_type r;
      r.s = si;
      r.s.mode = MODE_IDLE;
      r.e = '0;
      if (!eof && !is_space(b)) begin
         r.s.open_start  = p.off;
         r.s.open_length = LENGTH_BITS'(1);
         r.s.open_line   = p.line;
         r.s.open_col    = p.col;
         priority if (b == CH_MINUS) begin
            r.s.mode = MODE_MINUS;
            r.s.digit_seen = 1'b0;
         end else if (is_head(b)) begin
            r.s.mode = MODE_IDENT;
         end else if (is_digit(b)) begin
            r.s.mode = MODE_INT;
            r.s.digit_seen = 1'b1;
         end else if (b == CH_DOT) begin
            r.s.mode = MODE_FRAC;
            r.s.digit_seen = 1'b0;
         end else begin
            // single byte token, open fields stay as they were
            r.s = si;
            r.s.mode = MODE_IDLE;
            r.e.v = 1'b1;
            priority if (b == CH_OPEN) begin
               r.e.t = mk_tok(KIND_OPEN, p.off, LENGTH_BITS'(1), p.line, p.col);
            end else if (b == CH_CLOSE) begin
               r.e.t = mk_tok(KIND_CLOSE, p.off, LENGTH_BITS'(1), p.line, p.col);
            end else if (b == CH_COMMA) begin
               r.e.t = mk_tok(KIND_COMMA, p.off, LENGTH_BITS'(1), p.line, p.col);
            end else begin
               r.e.t = mk_tok(KIND_UNREC, p.off, LENGTH_BITS'(1), p.line, p.col);
            end
         end
      end
      return r;
   endfunction

   assign busy     = (rp_n_ff != 2'd0) || c_v_ff || e_v_ff;
   assign req_full = busy || q_full;
   assign accept   = req_push && !req_full;

   // line and column tracking runs at accept, independent of scanning
   always_comb begin
      cnt_now.off  = off_ff;
      cnt_now.line = line_ff;
      cnt_now.col  = col_ff;
      cnt_after    = cnt_now;
      if (req_byte_present) begin
         cnt_after.off = off_ff + OFFSET_BITS'(1);
         if (req_byte_value == CH_NL) begin
            cnt_after.line = pos_inc(line_ff);
            cnt_after.col  = POSITION_ONE;
         end else begin
            cnt_after.col = pos_inc(col_ff);
         end
      end
      off_in  = off_ff;
      line_in = line_ff;
      col_in  = col_ff;
      if (accept) begin
         if (req_source_ends) begin
            off_in  = '0;
            line_in = POSITION_ONE;
            col_in  = POSITION_ONE;
         end else begin
            off_in  = cnt_after.off;
            line_in = cnt_after.line;
            col_in  = cnt_after.col;
         end
      end
   end

   // pending work of the current word
   always_comb begin
      if (busy) begin
         w_rp_n = rp_n_ff;
         w_rp   = rp_ff;
         w_c_v  = c_v_ff;
         w_c    = c_ff;
         w_e_v  = e_v_ff;
         w_e    = e_ff;
      end else begin
         w_rp_n = '0;
         w_rp   = rp_ff;
         w_c_v  = accept && req_byte_present;
         w_c.b  = req_byte_value;
         w_c.p  = cnt_now;
         w_e_v  = accept && req_source_ends;
         w_e    = cnt_after;
      end
      h_rp     = (w_rp_n != 2'd0);
      heof     = !h_rp && !w_c_v;
      has_head = h_rp || w_c_v || w_e_v;
      step_en  = has_head && !q_full;
      hb       = h_rp ? w_rp[0].b : w_c.b;
      hp       = h_rp ? w_rp[0].p : (w_c_v ? w_c.p : w_e);
   end

   always_comb begin
      dig   = !heof && is_digit(hb);
      isdot = !heof && (hb == CH_DOT);
      is_e  = !heof && ((hb == CH_LE) || (hb == CH_UE));
      minus = !heof && (hb == CH_MINUS);
      sign  = !heof && ((hb == CH_PLUS) || (hb == CH_MINUS));
      body  = !heof && (is_head(hb) || is_digit(hb));
      nl    = !heof && (hb == CH_NL);
      bg    = beg(hb, heof, hp, scan_ff);
   end

   // one scanner step on the head byte
   always_comb begin
      sn       = scan_ff;
      consumed = 1'b1;
      e0       = '0;
      e1       = '0;
      nrp_n    = '0;
      nrp      = '0;
      fin      = 1'b0;
      bt       = 1'b0;
      fin_kind = KIND_NUMBER;
      unique case (scan_ff.mode)
         MODE_COMMENT: begin
            if (heof || nl) begin
               sn.mode = MODE_IDLE;
            end
         end
         MODE_MINUS: begin
            priority if (minus) begin
               sn.mode = MODE_COMMENT;
            end else if (dig) begin
               sn.open_length = len_add(scan_ff.open_length, 2'd1);
               sn.digit_seen = 1'b1;
               sn.mode = MODE_INT;
            end else if (isdot) begin
               sn.open_length = len_add(scan_ff.open_length, 2'd1);
               sn.digit_seen = 1'b0;
               sn.mode = MODE_FRAC;
            end else begin
               fin = 1'b1;
               fin_kind = KIND_UNREC;
            end
         end
         MODE_IDENT: begin
            if (body) begin
               sn.open_length = len_add(scan_ff.open_length, 2'd1);
            end else begin
               fin = 1'b1;
               fin_kind = KIND_IDENT;
            end
         end
         MODE_INT: begin
            priority if (dig) begin
               sn.open_length = len_add(scan_ff.open_length, 2'd1);
            end else if (isdot) begin
               sn.open_length = len_add(scan_ff.open_length, 2'd1);
               sn.mode = MODE_FRAC;
            end else if (is_e) begin
               sn.held0 = hb;
               sn.held_count = 2'd1;
               sn.mode = MODE_EXPMARK;
            end else begin
               fin = 1'b1;
            end
         end
         MODE_FRAC: begin
            priority if (dig) begin
               sn.open_length = len_add(scan_ff.open_length, 2'd1);
               sn.digit_seen = 1'b1;
            end else if (!scan_ff.digit_seen) begin
               // lone point or hyphen-point: first byte is unrecognised, rescan the rest
               consumed = 1'b0;
               sn.mode = MODE_IDLE;
               e0.v = 1'b1;
               e0.t = mk_tok(KIND_UNREC, scan_ff.open_start, LENGTH_BITS'(1),
                             scan_ff.open_line, scan_ff.open_col);
               if (scan_ff.open_length >= LENGTH_BITS'(2)) begin
                  nrp_n = 2'd1;
                  nrp[0].b = CH_DOT;
                  nrp[0].p.off  = scan_ff.open_start + OFFSET_BITS'(1);
                  nrp[0].p.line = scan_ff.open_line;
                  nrp[0].p.col  = pos_inc(scan_ff.open_col);
               end
            end else if (is_e) begin
               sn.held0 = hb;
               sn.held_count = 2'd1;
               sn.mode = MODE_EXPMARK;
            end else begin
               fin = 1'b1;
            end
         end
         MODE_EXPMARK: begin
            priority if (dig) begin
               sn.open_length = len_add(scan_ff.open_length, 2'd2);
               sn.held_count = 2'd0;
               sn.mode = MODE_EXPDIG;
            end else if (sign) begin
               sn.held1 = hb;
               sn.held_count = 2'd2;
               sn.mode = MODE_EXPSIGN;
            end else begin
               bt = 1'b1;
            end
         end
         MODE_EXPSIGN: begin
            if (dig) begin
               sn.open_length = len_add(scan_ff.open_length, 2'd3);
               sn.held_count = 2'd0;
               sn.mode = MODE_EXPDIG;
            end else begin
               bt = 1'b1;
            end
         end
         MODE_EXPDIG: begin
            if (dig) begin
               sn.open_length = len_add(scan_ff.open_length, 2'd1);
            end else begin
               fin = 1'b1;
            end
         end
         default: begin
            sn = bg.s;
            e0 = bg.e;
         end
      endcase

      if (fin) begin
         e0.v = 1'b1;
         e0.t = mk_tok(fin_kind, scan_ff.open_start, scan_ff.open_length,
                       scan_ff.open_line, scan_ff.open_col);
         sn = bg.s;
         e1 = bg.e;
      end

      // incomplete exponent: close the number, rescan the held marker and any held sign
      if (bt) begin
         consumed = 1'b0;
         sn.mode = MODE_IDLE;
         sn.held_count = 2'd0;
         e0.v = 1'b1;
         e0.t = mk_tok(KIND_NUMBER, scan_ff.open_start, scan_ff.open_length,
                       scan_ff.open_line, scan_ff.open_col);
         if (scan_ff.held_count == 2'd2) begin
            nrp_n = 2'd2;
            nrp[0].b = scan_ff.held0;
            nrp[0].p.off  = hp.off - OFFSET_BITS'(2);
            nrp[0].p.line = hp.line;
            nrp[0].p.col  = pos_back(hp.col, 2'd2);
            nrp[1].b = scan_ff.held1;
            nrp[1].p.off  = hp.off - OFFSET_BITS'(1);
            nrp[1].p.line = hp.line;
            nrp[1].p.col  = pos_back(hp.col, 2'd1);
         end else begin
            nrp_n = 2'd1;
            nrp[0].b = scan_ff.held0;
            nrp[0].p.off  = hp.off - OFFSET_BITS'(1);
            nrp[0].p.line = hp.line;
            nrp[0].p.col  = pos_back(hp.col, 2'd1);
         end
      end

      if (heof && consumed) begin
         e1.v = 1'b1;
         e1.t = mk_tok(KIND_END, hp.off, '0, hp.line, hp.col);
      end
   end

   // advance the pending work
   always_comb begin
      rp_n_in = w_rp_n;
      rp_in   = w_rp;
      c_v_in  = w_c_v;
      c_in    = w_c;
      e_v_in  = w_e_v;
      e_in    = w_e;
      scan_rst = scan_ff;
      scan_rst.mode        = MODE_IDLE;
      scan_rst.held_count  = '0;
      scan_rst.digit_seen  = 1'b0;
      scan_rst.open_start  = '0;
      scan_rst.open_length = '0;
      scan_rst.open_line   = POSITION_ONE;
      scan_rst.open_col    = POSITION_ONE;
      scan_in = scan_ff;
      if (step_en) begin
         scan_in = (heof && consumed) ? scan_rst : sn;
         if (consumed) begin
            priority if (h_rp) begin
               rp_in[0] = w_rp[1];
               rp_n_in  = w_rp_n - 2'd1;
            end else if (w_c_v) begin
               c_v_in = 1'b0;
            end else begin
               e_v_in = 1'b0;
            end
         end else begin
            rp_n_in = nrp_n;
            rp_in   = nrp;
         end
      end
      item_final = step_en && (rp_n_in == 2'd0) && !c_v_in && !e_v_in;
   end

   // gather tokens; the last one waits in carry until the word is done
   always_comb begin
      vv = {e1.v, e0.v, carry_v_ff};
      tv[0] = carry_ff;
      tv[1] = e0.t;
      tv[2] = e1.t;
      lst = '0;
      n = '0;
      for (int i = 0; i < 3; i++) begin
         if (vv[i]) begin
            lst[n] = tv[i];
            n = n + 2'd1;
         end
      end
      bundle.tok   = lst;
      bundle.count = n;
      bundle_push  = 1'b0;
      carry_v_in   = carry_v_ff;
      carry_in     = carry_ff;
      if (step_en) begin
         if (item_final) begin
            carry_v_in = 1'b0;
            if (n != 2'd0) begin
               bundle.tok[n - 2'd1].last = 1'b1;
               bundle_push = 1'b1;
            end
         end else if (n != 2'd0) begin
            carry_v_in   = 1'b1;
            carry_in     = lst[n - 2'd1];
            bundle.count = n - 2'd1;
            bundle_push  = (n > 2'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff.mode        <= MODE_IDLE;
         scan_ff.held0       <= '0;
         scan_ff.held1       <= '0;
         scan_ff.held_count  <= '0;
         scan_ff.digit_seen  <= 1'b0;
         scan_ff.open_start  <= '0;
         scan_ff.open_length <= '0;
         scan_ff.open_line   <= POSITION_ONE;
         scan_ff.open_col    <= POSITION_ONE;
         rp_n_ff    <= '0;
         c_v_ff     <= 1'b0;
         e_v_ff     <= 1'b0;
         carry_v_ff <= 1'b0;
         off_ff     <= '0;
         line_ff    <= POSITION_ONE;
         col_ff     <= POSITION_ONE;
      end else begin
         scan_ff    <= scan_in;
         rp_n_ff    <= rp_n_in;
         c_v_ff     <= c_v_in;
         e_v_ff     <= e_v_in;
         carry_v_ff <= carry_v_in;
         off_ff     <= off_in;
         line_ff    <= line_in;
         col_ff     <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      rp_ff    <= rp_in;
      c_ff     <= c_in;
      e_ff     <= e_in;
      carry_ff <= carry_in;
   end

endmodule
`default_nettype wire

FILE: rtl/core/bsl_queue.sv
// short queue of token bundles between front and back
`default_nettype none
module bsl_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                wr_en,
   input  wire bsl_pkg::bundle_type wr_data,
   output logic                     full,
   input  wire logic                rd_en,
   output bsl_pkg::bundle_type      rd_data,
   output logic                     empty
);
   import bsl_pkg::*;

   bundle_type mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0] count_ff, count_in;
   logic do_wr, do_rd;

   assign full    = (count_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      unique case ({do_wr, do_rd})
         2'b10:   count_in = count_ff + (QPTR_BITS+1)'(1);
         2'b01:   count_in = count_ff - (QPTR_BITS+1)'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/bsl_back.sv
// back end: splits bundles into single tokens behind an output register
`default_nettype none
module bsl_back (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire bsl_pkg::bundle_type                    head,
   input  wire logic                                   q_empty,
   output logic                                        q_pop,
   output logic                                        rsp_empty,
   input  wire logic                                   rsp_pop,
   output logic [bsl_pkg::KIND_BITS-1:0]               rsp_token_kind,
   output logic [bsl_pkg::OFFSET_BITS-1:0]             rsp_token_offset,
   output logic [bsl_pkg::LENGTH_BITS-1:0]             rsp_token_length,
   output logic [bsl_pkg::POSITION_BITS-1:0]           rsp_token_line,
   output logic [bsl_pkg::POSITION_BITS-1:0]           rsp_token_column,
   output logic                                        rsp_run_last
);
   import bsl_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic out_v_ff, out_v_in, load;
   token_type out_ff, out_in;

   always_comb begin
      load     = !q_empty && (!out_v_ff || rsp_pop);
      q_pop    = 1'b0;
      idx_in   = idx_ff;
      out_v_in = out_v_ff;
      out_in   = out_ff;
      if (load) begin
         out_in   = head.tok[idx_ff];
         out_v_in = 1'b1;
         if (idx_ff == head.count - 2'd1) begin
            q_pop  = 1'b1;
            idx_in = '0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end else if (rsp_pop) begin
         out_v_in = 1'b0;
      end
   end

   assign rsp_empty        = !out_v_ff;
   assign rsp_token_kind   = out_ff.kind;
   assign rsp_token_offset = out_ff.offset;
   assign rsp_token_length = out_ff.length;
   assign rsp_token_line   = out_ff.line;
   assign rsp_token_column = out_ff.column;
   assign rsp_run_last     = out_ff.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         out_v_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

endmodule
`default_nettype wire

FILE: rtl/core/byte_stream_lexer_unit.sv
// Byte stream lexer: source bytes in, token records out.
// Input channel: a word of byte_value, byte_present and source_ends is taken at a clock
// edge with req_push high and req_full low. Result channel: while rsp_empty is low the
// oldest token is on the rsp_ ports; rsp_pop takes it. run_last marks the last token
// caused by one input word.
// Throughput: one input word per cycle in the common case, set by the single scanner
// step that the front end performs each cycle. A word that ends the source takes one
// extra step for the flush; an incomplete exponent or a lone point takes one step per
// rescanned byte. req_full is high during these.
// With the result side idle, a word's tokens pass through the bundle queue and then
// the output register of the back end to the rsp_ ports; a token that a later byte
// of the same word may follow waits until that word is done.
// The output register reloads at the edge at which rsp_pop takes its token.
// When the receiver stalls, tokens pile up in a four-entry bundle queue and then
// req_full rises; nothing is dropped. After an end token the lexer returns to its
// reset state and the next word starts a new source at offset zero, line one.
// Reset (synchronous, active high) clears the scanner, counters and the bundle queue.
`default_nettype none
module byte_stream_lexer_unit (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_push,
   output logic                                        req_full,
   input  wire logic [7:0]                             req_byte_value,
   input  wire logic                                   req_byte_present,
   input  wire logic                                   req_source_ends,
   output logic                                        rsp_empty,
   input  wire logic                                   rsp_pop,
   output logic [bsl_pkg::KIND_BITS-1:0]               rsp_token_kind,
   output logic [bsl_pkg::OFFSET_BITS-1:0]             rsp_token_offset,
   output logic [bsl_pkg::LENGTH_BITS-1:0]             rsp_token_length,
   output logic [bsl_pkg::POSITION_BITS-1:0]           rsp_token_line,
   output logic [bsl_pkg::POSITION_BITS-1:0]           rsp_token_column,
   output logic                                        rsp_run_last
);
   import bsl_pkg::*;

   logic q_full, q_empty, q_pop, bundle_push;
   bundle_type bundle, head;

   bsl_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_byte_value   (req_byte_value),
      .req_byte_present (req_byte_present),
      .req_source_ends  (req_source_ends),
      .q_full           (q_full),
      .bundle_push      (bundle_push),
      .bundle           (bundle)
   );

   bsl_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (bundle_push),
      .wr_data (bundle),
      .full    (q_full),
      .rd_en   (q_pop),
      .rd_data (head),
      .empty   (q_empty)
   );

   bsl_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .q_empty          (q_empty),
      .q_pop            (q_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_offset (rsp_token_offset),
      .rsp_token_length (rsp_token_length),
      .rsp_token_line   (rsp_token_line),
      .rsp_token_column (rsp_token_column),
      .rsp_run_last     (rsp_run_last)
   );

endmodule
`default_nettype wire
